// ===== rtl/core/aligned_first_fit_arena_allocator_unit_assert.svh =====
// Assertion macros for the arena allocator unit.
// Used by the top level only; needs nothing else.
`ifndef ALIGNED_FIRST_FIT_ARENA_ALLOCATOR_UNIT_ASSERT_SVH
`define ALIGNED_FIRST_FIT_ARENA_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define AFFA_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AFFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/affa_pkg.sv =====
// Shared types, constants and the header write list of the arena allocator.
// No dependencies.
package affa_pkg;

    localparam int ARENA_MAX_BYTES_DEF = 65536;
    localparam int CFG_W  = 17;
    localparam int ADDR_W = 34;  // byte address incl. bits above the arena
    localparam int WORD_W = 32;
    localparam int LO_W   = 33;

    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE  = 2'd1;
    localparam logic [1:0] REQ_FILL  = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_RDW, S_WRW, S_ASTART, S_FIT, S_FITW,
        S_WTOP, S_WNXT, S_WSZ, S_WSEQ, S_FPRV, S_FNXT, S_FILL,
        S_READ, S_DONE
    } t_state;

    // which write list is run
    typedef enum logic [2:0] {
        K_EMPTY, K_FIRST, K_TAIL, K_MID, K_FCLR, K_FREE
    } t_kind;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] data;
        logic              last;
    } t_wop;

    // word write number 'step' of a link update
    function automatic t_wop wseq(input t_kind kind, input logic [2:0] step,
                                  input logic [15:0] h, input logic [WORD_W-1:0] start,
                                  input logic [WORD_W-1:0] nxt, input logic [WORD_W-1:0] i,
                                  input logic [WORD_W-1:0] prv, input logic [16:0] need);
        t_wop w;
        logic [WORD_W-1:0] nv;
        logic [WORD_W-1:0] pv;
        w.addr = '0;
        w.data = '0;
        w.last = 1'b1;
        nv = (kind == K_FIRST) ? start : ((kind == K_MID) ? nxt : '0);
        pv = (kind == K_TAIL || kind == K_MID) ? i : '0;
        case (kind)
            K_FCLR: begin
                w.addr = '0;
                w.data = '0;
                w.last = 1'b1;
            end
            K_FREE: begin
                if (step == 3'd0) begin
                    w.addr = ADDR_W'(prv);
                    w.data = nxt;
                    w.last = (nxt == '0);
                end else begin
                    w.addr = ADDR_W'(nxt) + ADDR_W'(4);
                    w.data = prv;
                    w.last = 1'b1;
                end
            end
            default: begin
                case (step)
                    3'd0: begin
                        w.addr = ADDR_W'(h);
                        w.data = nv;
                        w.last = 1'b0;
                    end
                    3'd1: begin
                        w.addr = ADDR_W'(h) + ADDR_W'(4);
                        w.data = pv;
                        w.last = 1'b0;
                    end
                    3'd2: begin
                        w.addr = ADDR_W'(h) + ADDR_W'(8);
                        w.data = WORD_W'(need);
                        w.last = 1'b0;
                    end
                    3'd3: begin
                        w.data = WORD_W'(h);
                        if (kind == K_TAIL) begin
                            w.addr = ADDR_W'(i);
                            w.last = 1'b1;
                        end else if (kind == K_MID) begin
                            w.addr = ADDR_W'(nxt) + ADDR_W'(4);
                            w.last = 1'b0;
                        end else begin
                            w.addr = '0;
                            w.last = (kind == K_EMPTY);
                        end
                    end
                    default: begin
                        w.data = WORD_W'(h);
                        w.addr = (kind == K_FIRST) ? (ADDR_W'(start) + ADDR_W'(4))
                                                   : ADDR_W'(i);
                        w.last = 1'b1;
                    end
                endcase
            end
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/affa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module affa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule

// ===== rtl/core/affa_div.sv =====
// Restoring divider, one quotient bit per cycle; returns the remainder.
// No dependencies.
module affa_div #(
    parameter int W = 17
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_rem
);
    localparam int CW = $clog2(W + 1);

    logic          r_busy, r_done;
    logic [CW-1:0] r_cnt;
    logic [W:0]    r_rem;
    logic [W-1:0]  r_quo, r_dvs;
    logic [W:0]    trial;

    assign trial = {r_rem[W-1:0], r_quo[W-1]};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= (trial >= {1'b0, r_dvs}) ? (trial - {1'b0, r_dvs}) : trial;
            r_quo <= {r_quo[W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[W-1:0];
endmodule

// ===== rtl/core/aligned_first_fit_arena_allocator_unit.sv =====
// Top level of the first-fit aligned arena allocator: sequencer and word access.
// Depends on affa_pkg, affa_ram, affa_div and the assertion header.
//
// Input channel: i_valid / o_stall with i_req_type, i_address, i_size, i_align,
// i_fill_byte. Output channel: o_valid / i_stall with o_result_address,
// o_read_data, o_ok. A transfer happens when valid is high and stall is low.
// One result per request. Config: i_cfg_we / i_cfg_wdata set arena_size.
// After reset a clearing pass zeroes the arena, with o_stall high. The block
// then takes one request at a time; o_stall stays high until the result is
// in the output register. Words go to and from the byte RAM byte by byte:
// a read fetches one word; a free reads the block's two link words and writes
// the neighbours' links; a fill writes size bytes; an allocate reads the list
// head, tries each gap with the remainder unit, reads the next and size words
// of each block walked, and then writes the header and link words.
// The next request is taken in the cycle after a result is loaded.
// A stalled result holds in the output register; the next request is taken
// meanwhile and its result waits until the register is free.
`include "aligned_first_fit_arena_allocator_unit_assert.svh"
module aligned_first_fit_arena_allocator_unit #(
    parameter int ARENA_MAX_BYTES = affa_pkg::ARENA_MAX_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_address,
    input  logic [15:0] i_size,
    input  logic [16:0] i_align,
    input  logic [7:0]  i_fill_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_result_address,
    output logic [7:0]  o_read_data,
    output logic        o_ok,
    input  logic        i_cfg_we,
    input  logic [16:0] i_cfg_wdata
);
    localparam int AW  = $clog2(ARENA_MAX_BYTES);
    localparam int AD  = affa_pkg::ADDR_W;
    localparam int WW  = affa_pkg::WORD_W;
    localparam int LW  = affa_pkg::LO_W;
    localparam int CW  = affa_pkg::CFG_W;

    // control registers
    affa_pkg::t_state r_state, n_state, r_ret, n_ret;
    logic             r_ovalid, n_ovalid;
    logic [AW-1:0]    r_clr, n_clr;
    logic [2:0]       r_cnt, n_cnt;
    logic [CW-1:0]    r_arena;

    // payload registers
    affa_pkg::t_kind  r_kind, n_kind;
    logic [2:0]       r_step, n_step;
    logic [15:0]      r_addr, n_addr, r_size, n_size;
    logic [16:0]      r_align, n_align;
    logic [7:0]       r_fb, n_fb;
    logic [AD-1:0]    r_waddr, n_waddr;
    logic [WW-1:0]    r_wdata, n_wdata, r_word, n_word;
    logic             r_inr, n_inr;
    logic [WW-1:0]    r_start, n_start, r_i, n_i, r_nxt, n_nxt, r_prv, n_prv;
    logic [LW-1:0]    r_lo, n_lo;
    logic [CW-1:0]    r_hi, n_hi;
    logic [15:0]      r_h, n_h;
    logic [16:0]      r_fk, n_fk;
    logic [15:0]      r_fcnt, n_fcnt;
    logic [15:0]      r_res, n_res, r_oaddr, n_oaddr;
    logic [7:0]       r_rdata, n_rdata, r_odata, n_odata;
    logic             r_okr, n_okr, r_ook, n_ook;

    // datapath nets
    logic [AD-1:0]    ba;
    logic             inr;
    logic [16:0]      need;
    logic [AD-1:0]    lo_need;
    logic [16:0]      fit_x;
    logic [17:0]      fit_d;
    logic [18:0]      fit_top;
    logic             fit_bad;
    logic [LW-1:0]    w_end;
    logic             div_start, div_done;
    logic [16:0]      div_rem;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    logic [7:0]       ram_wdata, ram_q;
    affa_pkg::t_wop   wop;

    affa_ram #(.WIDTH(8), .DEPTH(ARENA_MAX_BYTES)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_q)
    );

    affa_div #(.W(17)) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(fit_x),
        .i_divisor (r_align),
        .o_done    (div_done),
        .o_rem     (div_rem)
    );

    // byte address of the word access and arena range check
    assign ba      = r_waddr + AD'(r_cnt);
    assign inr     = ba < AD'(r_arena);
    assign need    = 17'(r_size) + 17'd12;
    assign lo_need = AD'(r_lo) + AD'(need);
    // aligned data offset: round lo+12 up to a multiple of align
    assign fit_x   = r_lo[16:0] + 17'd12;
    assign fit_d   = (div_rem == '0) ? 18'(fit_x) : (18'(fit_x) + 18'(r_align - div_rem));
    assign fit_top = 19'(fit_d) - 19'd12 + 19'(need);
    assign fit_bad = (fit_top > 19'(r_hi)) || (fit_d > 18'd65535);
    assign w_end   = LW'(r_i) + LW'(r_word);
    assign wop     = affa_pkg::wseq(r_kind, r_step, r_h, r_start, r_nxt, r_i, r_prv, need);

    // next state and register values
    always_comb begin
        n_state = r_state;  n_ret = r_ret;   n_ovalid = r_ovalid && i_stall;
        n_clr = r_clr;      n_cnt = r_cnt;   n_kind = r_kind;   n_step = r_step;
        n_addr = r_addr;    n_size = r_size; n_align = r_align;
        n_fb = r_fb;        n_waddr = r_waddr; n_wdata = r_wdata; n_word = r_word;
        n_inr = r_inr;      n_start = r_start; n_i = r_i; n_nxt = r_nxt; n_prv = r_prv;
        n_lo = r_lo;        n_hi = r_hi;     n_h = r_h;   n_fk = r_fk; n_fcnt = r_fcnt;
        n_res = r_res;      n_rdata = r_rdata; n_okr = r_okr;
        n_oaddr = r_oaddr;  n_odata = r_odata; n_ook = r_ook;
        case (r_state)
            affa_pkg::S_CLR: begin
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(ARENA_MAX_BYTES - 1)) begin
                    n_state = affa_pkg::S_IDLE;
                end
            end
            affa_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_addr = i_address; n_size = i_size;
                    n_align = i_align;  n_fb = i_fill_byte;
                    n_res = '0; n_rdata = '0; n_okr = 1'b1; n_cnt = '0;
                    case (i_req_type)
                        affa_pkg::REQ_ALLOC: begin
                            if (i_align == '0) begin
                                n_okr = 1'b0;
                                n_state = affa_pkg::S_DONE;
                            end else begin
                                n_waddr = '0;
                                n_ret = affa_pkg::S_ASTART;
                                n_state = affa_pkg::S_RDW;
                            end
                        end
                        affa_pkg::REQ_FREE: begin
                            if (i_address < 16'd16 || 17'(i_address) >= r_arena) begin
                                n_state = affa_pkg::S_DONE;
                            end else begin
                                n_waddr = AD'(i_address - 16'd8);
                                n_ret = affa_pkg::S_FPRV;
                                n_state = affa_pkg::S_RDW;
                            end
                        end
                        affa_pkg::REQ_FILL: begin
                            n_fk = 17'(i_address);
                            n_fcnt = i_size;
                            n_state = affa_pkg::S_FILL;
                        end
                        default: begin
                            n_waddr = AD'(i_address);
                            n_ret = affa_pkg::S_READ;
                            n_state = affa_pkg::S_RDW;
                        end
                    endcase
                end
            end
            // four byte reads, little-endian, bytes outside the arena read 0
            affa_pkg::S_RDW: begin
                n_inr = inr;
                if (r_cnt != '0) begin
                    n_word = {(r_inr ? ram_q : 8'h00), r_word[WW-1:8]};
                end
                if (r_cnt == 3'd4) begin
                    n_cnt = '0;
                    n_state = r_ret;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            affa_pkg::S_WRW: begin
                n_wdata = r_wdata >> 8;
                if (r_cnt == 3'd3) begin
                    n_cnt = '0;
                    n_state = r_ret;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            affa_pkg::S_READ: begin
                n_rdata = r_word[7:0];
                n_state = affa_pkg::S_DONE;
            end
            affa_pkg::S_FILL: begin
                if (r_fcnt == '0) begin
                    n_state = affa_pkg::S_DONE;
                end else begin
                    n_fk = r_fk + 17'd1;
                    n_fcnt = r_fcnt - 16'd1;
                end
            end
            affa_pkg::S_FPRV: begin
                n_prv = r_word;
                n_waddr = AD'(r_addr - 16'd12);
                n_ret = affa_pkg::S_FNXT;
                n_state = affa_pkg::S_RDW;
            end
            affa_pkg::S_FNXT: begin
                n_nxt = r_word;
                n_kind = (r_prv == r_word) ? affa_pkg::K_FCLR : affa_pkg::K_FREE;
                n_step = '0;
                n_state = affa_pkg::S_WSEQ;
            end
            affa_pkg::S_ASTART: begin
                n_start = r_word;
                n_lo = LW'(4);
                if (r_word == '0) begin
                    n_kind = affa_pkg::K_EMPTY;
                    n_hi = r_arena;
                end else begin
                    n_kind = affa_pkg::K_FIRST;
                    n_hi = (r_word < WW'(r_arena)) ? r_word[CW-1:0] : r_arena;
                end
                n_state = affa_pkg::S_FIT;
            end
            // gap check, then wait for the remainder unit
            affa_pkg::S_FIT: begin
                if (lo_need > AD'(r_hi)) begin
                    case (r_kind)
                        affa_pkg::K_FIRST: begin
                            n_i = r_start;
                            n_state = affa_pkg::S_WTOP;
                        end
                        affa_pkg::K_MID: begin
                            n_i = r_nxt;
                            n_state = affa_pkg::S_WTOP;
                        end
                        default: begin
                            n_okr = 1'b0;
                            n_state = affa_pkg::S_DONE;
                        end
                    endcase
                end else begin
                    n_state = affa_pkg::S_FITW;
                end
            end
            affa_pkg::S_FITW: begin
                if (div_done) begin
                    if (fit_bad) begin
                        case (r_kind)
                            affa_pkg::K_FIRST: begin
                                n_i = r_start;
                                n_state = affa_pkg::S_WTOP;
                            end
                            affa_pkg::K_MID: begin
                                n_i = r_nxt;
                                n_state = affa_pkg::S_WTOP;
                            end
                            default: begin
                                n_okr = 1'b0;
                                n_state = affa_pkg::S_DONE;
                            end
                        endcase
                    end else begin
                        n_h = 16'(fit_d - 18'd12);
                        n_res = fit_d[15:0];
                        n_step = '0;
                        n_state = affa_pkg::S_WSEQ;
                    end
                end
            end
            // block list walk
            affa_pkg::S_WTOP: begin
                if (r_i >= WW'(r_arena)) begin
                    n_okr = 1'b0;
                    n_state = affa_pkg::S_DONE;
                end else begin
                    n_waddr = AD'(r_i);
                    n_ret = affa_pkg::S_WNXT;
                    n_state = affa_pkg::S_RDW;
                end
            end
            affa_pkg::S_WNXT: begin
                n_nxt = r_word;
                n_waddr = AD'(r_i) + AD'(8);
                n_ret = affa_pkg::S_WSZ;
                n_state = affa_pkg::S_RDW;
            end
            affa_pkg::S_WSZ: begin
                n_lo = w_end;
                if (r_nxt == '0) begin
                    n_kind = affa_pkg::K_TAIL;
                    n_hi = r_arena;
                    n_state = affa_pkg::S_FIT;
                end else if (r_nxt <= r_i) begin
                    n_okr = 1'b0;
                    n_state = affa_pkg::S_DONE;
                end else begin
                    n_kind = affa_pkg::K_MID;
                    n_hi = (r_nxt < WW'(r_arena)) ? r_nxt[CW-1:0] : r_arena;
                    n_state = affa_pkg::S_FIT;
                end
            end
            // header and link word writes
            affa_pkg::S_WSEQ: begin
                n_waddr = wop.addr;
                n_wdata = wop.data;
                n_ret = wop.last ? affa_pkg::S_DONE : affa_pkg::S_WSEQ;
                n_step = r_step + 3'd1;
                n_cnt = '0;
                n_state = affa_pkg::S_WRW;
            end
            affa_pkg::S_DONE: begin
                if (!r_ovalid || !i_stall) begin
                    n_ovalid = 1'b1;
                    n_oaddr = r_res;
                    n_odata = r_rdata;
                    n_ook = r_okr;
                    n_state = affa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = affa_pkg::S_IDLE;
            end
        endcase
    end

    // RAM port, remainder unit start and input stall
    always_comb begin
        ram_we = 1'b0;
        ram_waddr = ba[AW-1:0];
        ram_wdata = r_wdata[7:0];
        ram_raddr = ba[AW-1:0];
        div_start = 1'b0;
        o_stall = (r_state != affa_pkg::S_IDLE);
        case (r_state)
            affa_pkg::S_CLR: begin
                ram_we = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = 8'h00;
            end
            affa_pkg::S_WRW: begin
                ram_we = inr;
            end
            affa_pkg::S_FILL: begin
                ram_we = (r_fcnt != '0) && (r_fk < r_arena);
                ram_waddr = r_fk[AW-1:0];
                ram_wdata = r_fb;
            end
            affa_pkg::S_FIT: begin
                div_start = !(lo_need > AD'(r_hi));
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= affa_pkg::S_CLR;
            r_ret    <= affa_pkg::S_IDLE;
            r_ovalid <= 1'b0;
            r_clr    <= '0;
            r_cnt    <= '0;
            r_arena  <= CW'(ARENA_MAX_BYTES);
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_ovalid <= n_ovalid;
            r_clr    <= n_clr;
            r_cnt    <= n_cnt;
            // arena size, clamped to the legal range
            if (i_cfg_we) begin
                if (i_cfg_wdata < CW'(16)) begin
                    r_arena <= CW'(16);
                end else if (i_cfg_wdata > CW'(ARENA_MAX_BYTES)) begin
                    r_arena <= CW'(ARENA_MAX_BYTES);
                end else begin
                    r_arena <= i_cfg_wdata;
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;   r_step <= n_step;
        r_addr <= n_addr;   r_size <= n_size;   r_align <= n_align;  r_fb <= n_fb;
        r_waddr <= n_waddr; r_wdata <= n_wdata; r_word <= n_word;    r_inr <= n_inr;
        r_start <= n_start; r_i <= n_i;         r_nxt <= n_nxt;      r_prv <= n_prv;
        r_lo <= n_lo;       r_hi <= n_hi;       r_h <= n_h;
        r_fk <= n_fk;       r_fcnt <= n_fcnt;
        r_res <= n_res;     r_rdata <= n_rdata; r_okr <= n_okr;
        r_oaddr <= n_oaddr; r_odata <= n_odata; r_ook <= n_ook;
    end

    assign o_valid          = r_ovalid;
    assign o_result_address = r_oaddr;
    assign o_read_data      = r_odata;
    assign o_ok             = r_ook;

    // checks
    `AFFA_ASSERT_IMPLY(a_clr_stall, i_clk, i_rst_n, r_state == affa_pkg::S_CLR, o_stall, "input taken during clearing pass")
    `AFFA_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, i_valid && !o_stall, o_stall, "second transfer taken while busy")
    `AFFA_ASSERT_IMPLY(a_fail_addr, i_clk, i_rst_n, o_valid && !o_ok, o_result_address == '0 && o_read_data == '0, "failed allocation carries data")
    `AFFA_ASSERT_IMPLY(a_read_only, i_clk, i_rst_n, o_valid && o_read_data != '0, o_ok && o_result_address == '0, "read byte on a non-read result")
endmodule

// ===== verif/tb_aligned_first_fit_arena_allocator_unit.sv =====
// Testbench for the first-fit aligned arena allocator unit.
// Predicts each result from a byte-array arena kept here; depends on affa_pkg and the RTL.
`timescale 1ns / 1ps
module tb_aligned_first_fit_arena_allocator_unit;

    localparam int HDR = 12;
    localparam int START_W = 4;
    localparam int IDLE_LIMIT = 400000;
    localparam int LONG_HOLD = 400;

    typedef struct {
        logic [1:0]  kind;
        logic [15:0] addr;
        logic [15:0] len;
        logic [16:0] align;
        logic [7:0]  fill;
    } t_arena_req;

    typedef struct {
        logic [15:0] addr;
        logic [7:0]  rdata;
        logic        ok;
    } t_arena_rsp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [1:0]  i_req_type = '0;
    logic [15:0] i_address = '0;
    logic [15:0] i_size = '0;
    logic [16:0] i_align = '0;
    logic [7:0]  i_fill_byte = '0;
    logic        i_stall = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [16:0] i_cfg_wdata = '0;
    logic        o_stall;
    logic        o_valid;
    logic [15:0] o_result_address;
    logic [7:0]  o_read_data;
    logic        o_ok;

    aligned_first_fit_arena_allocator_unit u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_req_type(i_req_type), .i_address(i_address), .i_size(i_size),
        .i_align(i_align), .i_fill_byte(i_fill_byte),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_result_address(o_result_address), .o_read_data(o_read_data), .o_ok(o_ok),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // arena copy and bookkeeping; the arena starts all zero as after reset
    logic [7:0]  arena [0:65535] = '{default: 8'h00};
    longint      arena_len = 65536;
    t_arena_rsp  pending_results[$];
    logic [15:0] live_addr[$];
    logic [15:0] live_len[$];
    int          fails = 0;
    bit          quiet = 1'b0;
    bit          hold_req = 1'b0;

    function automatic longint peek8(longint a);
        return (a < arena_len) ? longint'(arena[a]) : 0;
    endfunction

    function automatic void poke8(longint a, longint v);
        if (a < arena_len) arena[a] = v[7:0];
    endfunction

    function automatic longint peek32(longint a);
        return peek8(a) | (peek8(a + 1) << 8) | (peek8(a + 2) << 16) | (peek8(a + 3) << 24);
    endfunction

    function automatic void poke32(longint a, longint v);
        for (int b = 0; b < 4; b++) poke8(a + b, (v >> (8 * b)) & 255);
    endfunction

    // lowest header offset in [lo, hi-need] whose data offset is aligned
    function automatic bit gap_fit(longint lo, longint hi, longint need, longint al,
                                   output longint h);
        longint d;
        h = 0;
        if (hi > arena_len) hi = arena_len;
        if (lo + need > hi) return 0;
        d = ((lo + HDR + al - 1) / al) * al;
        if (d - HDR + need > hi || d > 65535) return 0;
        h = d - HDR;
        return 1;
    endfunction

    function automatic void write_header(longint h, longint nx, longint pv, longint need);
        poke32(h, nx);
        poke32(h + 4, pv);
        poke32(h + 8, need);
    endfunction

    function automatic longint first_fit_alloc(longint len, longint al);
        longint need, head, h, cur, nx, fin;
        need = len + HDR;
        if (al == 0) return 0;
        head = peek32(0);
        if (head == 0) begin
            if (!gap_fit(START_W, arena_len, need, al, h)) return 0;
            write_header(h, 0, 0, need);
            poke32(0, h);
            return h + HDR;
        end
        if (gap_fit(START_W, head, need, al, h)) begin
            write_header(h, head, 0, need);
            poke32(0, h);
            poke32(head + 4, h);
            return h + HDR;
        end
        cur = head;
        forever begin
            if (cur >= arena_len) return 0;
            nx = peek32(cur);
            fin = cur + peek32(cur + 8);
            if (nx == 0) begin
                if (!gap_fit(fin, arena_len, need, al, h)) return 0;
                write_header(h, 0, cur, need);
                poke32(cur, h);
                return h + HDR;
            end
            if (nx <= cur) return 0;
            if (gap_fit(fin, nx, need, al, h)) begin
                write_header(h, nx, cur, need);
                poke32(nx + 4, h);
                poke32(cur, h);
                return h + HDR;
            end
            cur = nx;
        end
    endfunction

    function automatic void unlink_block(longint a);
        longint pv, nx;
        if (a < 16 || a >= arena_len) return;
        pv = peek32(a - 8);
        nx = peek32(a - 12);
        if (pv == nx) begin
            poke32(0, 0);
            return;
        end
        poke32(pv, nx);
        if (nx != 0) poke32(nx + 4, pv);
    endfunction

    function automatic t_arena_rsp arena_predict(t_arena_req r);
        t_arena_rsp e;
        longint res;
        e.addr = '0;
        e.rdata = '0;
        e.ok = 1'b1;
        case (r.kind)
            affa_pkg::REQ_ALLOC: begin
                res = first_fit_alloc(r.len, r.align);
                e.addr = res[15:0];
                e.ok = (res != 0);
            end
            affa_pkg::REQ_FREE: unlink_block(r.addr);
            affa_pkg::REQ_FILL: begin
                for (longint k = 0; k < r.len; k++) poke8(longint'(r.addr) + k, r.fill);
            end
            default: e.rdata = 8'(peek8(r.addr));
        endcase
        return e;
    endfunction

    // one transfer on the request channel; call right after a rising edge
    task automatic send_req(t_arena_req r);
        t_arena_rsp e;
        i_valid <= 1'b1;
        i_req_type <= r.kind;
        i_address <= r.addr;
        i_size <= r.len;
        i_align <= r.align;
        i_fill_byte <= r.fill;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        e = arena_predict(r);
        pending_results.push_back(e);
        if (r.kind == affa_pkg::REQ_ALLOC && e.ok) begin
            live_addr.push_back(e.addr);
            live_len.push_back(r.len);
        end
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    task automatic send_fields(logic [1:0] k, logic [15:0] a, logic [15:0] n,
                               logic [16:0] al, logic [7:0] fb);
        t_arena_req r;
        r.kind = k;
        r.addr = a;
        r.len = n;
        r.align = al;
        r.fill = fb;
        send_req(r);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
    endtask

    // arena_size write while idle; block list is restarted empty
    task automatic set_arena_len(logic [16:0] v);
        drain_results();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        arena_len = (v < 16) ? 16 : ((v > 65536) ? 65536 : longint'(v));
        live_addr.delete();
        live_len.delete();
        send_fields(affa_pkg::REQ_FILL, 16'd0, 16'd4, 17'd1, 8'h00);
    endtask

    function automatic logic [16:0] pick_align();
        int p;
        p = $urandom_range(0, 99);
        if (p < 3) return 17'd0;
        if (p < 5) return 17'd65536;
        if (p < 10) return 17'($urandom_range(0, 131071));
        return 17'(1) << $urandom_range(0, 8);
    endfunction

    // mostly well-formed traffic on live blocks, some noise
    function automatic t_arena_req pick_req();
        t_arena_req r;
        int p, j;
        p = $urandom_range(0, 99);
        r.kind = affa_pkg::REQ_READ;
        r.addr = 16'($urandom);
        r.len = 16'($urandom_range(0, 64));
        r.align = 17'($urandom);
        r.fill = 8'($urandom);
        if (p < 10) begin
            r.kind = 2'($urandom);
            if (r.kind == affa_pkg::REQ_ALLOC) r.len = 16'($urandom);
        end else if (live_addr.size() == 0 || p < 35 && live_addr.size() < 12) begin
            r.kind = affa_pkg::REQ_ALLOC;
            r.len = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 256));
            r.align = pick_align();
        end else begin
            j = $urandom_range(0, live_addr.size() - 1);
            r.addr = live_addr[j];
            if (p < 55 || live_addr.size() >= 12) begin
                r.kind = affa_pkg::REQ_FREE;
                live_addr.delete(j);
                live_len.delete(j);
            end else if (p < 75) begin
                r.kind = affa_pkg::REQ_FILL;
                r.len = 16'($urandom_range(0, live_len[j]));
            end else begin
                r.addr = live_addr[j] + 16'($urandom_range(0, live_len[j] + 12)) - 16'(12);
            end
        end
        return r;
    endfunction

    // result check and receiver stall pattern
    int stall_left = 0;
    int hold_left = 0;
    always @(posedge i_clk) begin
        t_arena_rsp e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected");
                fails++;
            end else begin
                e = pending_results.pop_front();
                if (o_result_address !== e.addr) begin
                    $error("result_address expected %0h got %0h", e.addr, o_result_address);
                    fails++;
                end
                if (o_read_data !== e.rdata) begin
                    $error("read_data expected %0h got %0h", e.rdata, o_read_data);
                    fails++;
                end
                if (o_ok !== e.ok) begin
                    $error("ok expected %0b got %0b", e.ok, o_ok);
                    fails++;
                end
            end
        end
        if (hold_req) begin
            hold_req <= 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 18);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // watchdog: cycles without any transfer
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic test_directed();
        send_fields(affa_pkg::REQ_READ, 16'd0, 16'd0, 17'd0, 8'h00);
        send_fields(affa_pkg::REQ_ALLOC, 16'd0, 16'd8, 17'd0, 8'h00);      // zero alignment
        send_fields(affa_pkg::REQ_ALLOC, 16'd0, 16'd0, 17'd1, 8'h00);      // first block
        send_fields(affa_pkg::REQ_ALLOC, 16'd0, 16'hFFFF, 17'd1, 8'h00);   // too big
        send_fields(affa_pkg::REQ_ALLOC, 16'd0, 16'd4, 17'd65536, 8'h00);  // offset 65536
        send_fields(affa_pkg::REQ_ALLOC, 16'd0, 16'd40, 17'd64, 8'h00);    // tail, aligned
        send_fields(affa_pkg::REQ_ALLOC, 16'd0, 16'd3, 17'd1, 8'h00);      // gap between blocks
        send_fields(affa_pkg::REQ_FILL, 16'd64, 16'd40, 17'd1, 8'hFF);
        send_fields(affa_pkg::REQ_READ, 16'd64, 16'd0, 17'd1, 8'h00);
        send_fields(affa_pkg::REQ_READ, 16'hFFFF, 16'hFFFF, 17'h1FFFF, 8'hFF);
        send_fields(affa_pkg::REQ_FREE, 16'd15, 16'd0, 17'd1, 8'h00);      // below 16
        send_fields(affa_pkg::REQ_FREE, 16'd16, 16'd0, 17'd1, 8'h00);      // first block
        send_fields(affa_pkg::REQ_ALLOC, 16'd0, 16'd0, 17'd16, 8'h00);     // gap before first
        send_fields(affa_pkg::REQ_FREE, 16'd64, 16'd0, 17'd1, 8'h00);
        send_fields(affa_pkg::REQ_FILL, 16'd0, 16'd0, 17'd1, 8'h55);       // empty run
        send_fields(affa_pkg::REQ_FILL, 16'h8000, 16'hFFFF, 17'd1, 8'hA5); // runs past the arena
        send_fields(affa_pkg::REQ_READ, 16'hFFFF, 16'd0, 17'd1, 8'h00);
        send_fields(affa_pkg::REQ_FILL, 16'd0, 16'd4, 17'd1, 8'h00);
        send_fields(affa_pkg::REQ_ALLOC, 16'd0, 16'd20, 17'h1FFFF, 8'h00); // alignment beyond reach
        send_fields(affa_pkg::REQ_ALLOC, 16'd0, 16'd20, 17'd3, 8'h00);
        send_fields(affa_pkg::REQ_FREE, 16'd0, 16'd0, 17'd1, 8'h00);
    endtask

    task automatic test_small_arena();
        set_arena_len(17'd0);                                              // clamps to 16
        send_fields(affa_pkg::REQ_ALLOC, 16'd0, 16'd0, 17'd1, 8'h00);
        send_fields(affa_pkg::REQ_ALLOC, 16'd0, 16'd0, 17'd1, 8'h00);
        send_fields(affa_pkg::REQ_READ, 16'd16, 16'd0, 17'd1, 8'h00);
        send_fields(affa_pkg::REQ_FILL, 16'd8, 16'd20, 17'd1, 8'h3C);
        send_fields(affa_pkg::REQ_READ, 16'd15, 16'd0, 17'd1, 8'h00);
        send_fields(affa_pkg::REQ_FREE, 16'd16, 16'd0, 17'd1, 8'h00);      // at arena end
        for (int n = 0; n < 40; n++) send_req(pick_req());
    endtask

    task automatic test_random(int count);
        for (int n = 0; n < count; n++) send_req(pick_req());
    endtask

    task automatic test_backpressure();
        @(posedge i_clk);
        hold_req <= 1'b1;
        for (int n = 0; n < 12; n++) send_req(pick_req());
    endtask

    task automatic test_sender_pause();
        drain_results();
        test_random(30);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(120);
        test_backpressure();
        test_small_arena();
        set_arena_len(17'd256);
        test_random(80);
        set_arena_len(17'h1FFFF);                                          // clamps to 65536
        test_random(120);
        test_sender_pause();
        set_arena_len(17'd4096);
        test_random(80);
        test_backpressure();
        set_arena_len(17'd65536);
        quiet = 1'b1;
        test_random(150);
        drain_results();
        if (fails == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
